/* hdl/ssi_pkg.sv */
`timescale 1ns / 1ps
// ssi_pkg: shared types, codes and sizes for the sorted set insert unit
// used by ssi_cell and sorted_set_insert_unit; no dependencies

package ssi_pkg;

   localparam int CAPACITY   = 16;
   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_CNT_W = 5;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   // wide enough for the count, the read index and the reported count
   localparam int CMP_W      = (CNT_W > ENTRY_CNT_W) ? CNT_W : ENTRY_CNT_W;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // per-cell control from the top level
   typedef struct packed {
      logic write_en;   // commit an insert this cycle
      logic valid;      // slot holds a stored entry
      logic left_less;  // left neighbor is below the new value (true for slot 0)
   } cell_ctl_type;

   // per-cell compare results
   typedef struct packed {
      logic less;
      logic equal;
   } cell_flags_type;

endpackage

/* hdl/ssi_cell.sv */
`timescale 1ns / 1ps
// ssi_cell: one slot of the sorted chain, holds an entry and compares it
// against the incoming value; depends on ssi_pkg

module ssi_cell (
   input  logic                                clock,
   input  ssi_pkg::cell_ctl_type               ctl,
   input  logic signed [ssi_pkg::VALUE_W-1:0]  new_value,
   input  logic signed [ssi_pkg::VALUE_W-1:0]  left_entry,
   output ssi_pkg::cell_flags_type             flags,
   output logic signed [ssi_pkg::VALUE_W-1:0]  entry
);
   import ssi_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   assign flags.less  = ctl.valid && (entry_ff < new_value);
   assign flags.equal = ctl.valid && (entry_ff == new_value);
   assign entry       = entry_ff;

   // smaller entries stay, the first larger slot takes the new value,
   // everything above moves up one from the left neighbor
   always_comb begin
      entry_in = entry_ff;
      if (ctl.write_en && !flags.less) begin
         if (ctl.left_less) begin
            entry_in = new_value;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* hdl/sorted_set_insert_unit.sv */
`timescale 1ns / 1ps
// Sorted set insert unit: a bounded set of signed 32-bit values kept in
// ascending order without duplicates, held in a chain of ssi_cell slots.
//
// Request channel (req_valid / req_stall): req_kind selects insert of
// req_value or read of the entry at req_index. Every request transfer
// produces exactly one response transfer (rsp_valid / rsp_stall) with a
// status, the entry count after the request and the read value.
// All slots compare against the new value in parallel and shift together
// in the same cycle, so one request is taken every cycle while req_stall
// is low, and its response appears in the cycle after the transfer from
// the response register.
// An insert of a value already present returns duplicate, an insert into
// a full set returns full, and a read at or beyond the count returns
// index out of range with a zero value.
// Reset (synchronous, active high) empties the set at once and drops any
// pending response. While the receiver stalls, the response holds and
// req_stall is raised, so requests wait without loss.
// Depends on ssi_pkg and ssi_cell.

module sorted_set_insert_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [ssi_pkg::VALUE_W-1:0]   req_value,
   input  logic [ssi_pkg::INDEX_W-1:0]          req_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssi_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ssi_pkg::ENTRY_CNT_W-1:0]      rsp_entry_count,
   output logic signed [ssi_pkg::VALUE_W-1:0]   rsp_read_value
);
   import ssi_pkg::*;

   cell_ctl_type              ctl   [CAPACITY];
   cell_flags_type            flags [CAPACITY];
   logic signed [VALUE_W-1:0] entry [CAPACITY];

   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   status_type                rsp_status_ff;
   status_type                rsp_status_in;
   logic [ENTRY_CNT_W-1:0]    rsp_count_ff;
   logic [ENTRY_CNT_W-1:0]    rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_read_ff;
   logic signed [VALUE_W-1:0] rsp_read_in;

   logic                      accept;
   logic                      is_dup;
   logic                      is_full;
   logic                      do_insert;
   logic                      in_range;
   logic signed [VALUE_W-1:0] read_sel;
   logic [CMP_W-1:0]          count_wide;
   logic                      sorted_ok;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_dup = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         is_dup = is_dup | flags[i].equal;
      end
   end

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign do_insert = accept && (req_kind == KIND_INSERT) && !is_dup && !is_full;

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign ctl[i].write_en = do_insert;
      assign ctl[i].valid    = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_head
         assign ctl[i].left_less = 1'b1;
         ssi_cell u_cell (
            .clock      (clock),
            .ctl        (ctl[i]),
            .new_value  (req_value),
            .left_entry (req_value),
            .flags      (flags[i]),
            .entry      (entry[i])
         );
      end else begin : g_body
         assign ctl[i].left_less = flags[i-1].less;
         ssi_cell u_cell (
            .clock      (clock),
            .ctl        (ctl[i]),
            .new_value  (req_value),
            .left_entry (entry[i-1]),
            .flags      (flags[i]),
            .entry      (entry[i])
         );
      end
   end

   // read select
   assign in_range = (CMP_W'(req_index) < CMP_W'(count_ff));
   always_comb begin
      read_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (CMP_W'(req_index) == CMP_W'(i)) begin
            read_sel = entry[i];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_read_in  = '0;
         if (req_kind == KIND_READ) begin
            if (in_range) begin
               rsp_status_in = ST_OK;
               rsp_read_in   = read_sel;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end else if (is_dup) begin
            rsp_status_in = ST_DUP;
         end else if (is_full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_OK;
         end
      end
   end

   assign count_wide   = CMP_W'(count_in);
   assign rsp_count_in = accept ? count_wide[ENTRY_CNT_W-1:0] : rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_value  = rsp_read_ff;

   // stored entries strictly ascending
   always_comb begin
      sorted_ok = 1'b1;
      for (int i = 1; i < CAPACITY; i++) begin
         if (ctl[i].valid && !(entry[i-1] < entry[i])) begin
            sorted_ok = 1'b0;
         end
      end
   end

   a_sorted: assert property (@(posedge clock) disable iff (reset) sorted_ok)
      else $error("stored entries out of order");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      do_insert |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the set by one");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("transfer without a response");

endmodule
